/* src/clcd_pkg.sv */
// Shared types and constants for the 4-bit character LCD command engine.
// Used by char_lcd_4bit_command_engine; has no dependencies of its own.
package clcd_pkg;

  typedef enum logic [2:0] {
    FN_INIT   = 3'd0,
    FN_CLEAR  = 3'd1,
    FN_CURSOR = 3'd2,
    FN_LINE   = 3'd3,
    FN_CHAR   = 3'd4,
    FN_NUMBER = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EMIT  = 3'b010,
    S_DIGIT = 3'b100
  } state_t;

  localparam int LINE_CHARS_DEF = 16;

  localparam logic [7:0] CMD_ROW0     = 8'h80;
  localparam logic [7:0] CMD_ROW1     = 8'hC0;
  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_4BIT     = 4'h2;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;

  localparam logic [13:0] WAIT_BOOT  = 14'd15000;
  localparam logic [12:0] WAIT_POWER = 13'd5100;
  localparam logic [12:0] WAIT_HIGH  = 13'd100;
  localparam logic [12:0] WAIT_LOW   = 13'd200;
  localparam logic [12:0] WAIT_CLEAR = 13'd2200;

  localparam logic [2:0] PLACE_LAST = 3'd4;

  function automatic logic [15:0] pow10(input logic [2:0] place);
    logic [15:0] p;
    unique case (place)
      3'd0:    p = 16'd10000;
      3'd1:    p = 16'd1000;
      3'd2:    p = 16'd100;
      3'd3:    p = 16'd10;
      default: p = 16'd1;
    endcase
    return p;
  endfunction

endpackage

/* src/char_lcd_4bit_command_engine.sv */
// Character LCD command engine: expands one display command into 4-bit transfers.
// Depends on clcd_pkg for command codes, states, byte constants and the power-of-ten table.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   in      | in_valid / in_stall  | func, row, col, char_code, number
//   out     | out_valid / out_stall| reg_select, nibble, wait_before_us, wait_after_us, last
//
// Each accepted item emits its transfers, advancing only while the output is not stalled:
// init 12 transfers, clear, cursor and char 2, clear line 2*LINE_CHARS+4.
// Write number runs a shared compare/subtract unit, subtracting the power of ten to
// close each decimal place, then sends each printed digit as 2 transfers.
// in_stall is high from acceptance until the final transfer is loaded into the output register.
// Synchronous reset clears the sequencer and the output valid; codes 6 and 7 produce nothing.
module char_lcd_4bit_command_engine #(
  parameter int LINE_CHARS = clcd_pkg::LINE_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic        row,
  input  logic [5:0]  col,
  input  logic [7:0]  char_code,
  input  logic [15:0] number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        reg_select,
  output logic [3:0]  nibble,
  output logic [13:0] wait_before_us,
  output logic [12:0] wait_after_us,
  output logic        last
);
  import clcd_pkg::*;

  localparam int STEP_N = (2 * LINE_CHARS + 4 > 12) ? 2 * LINE_CHARS + 4 : 12;
  localparam int STEP_W = $clog2(STEP_N);

  state_t            state;
  func_t             func_r;
  logic              row_r;
  logic [5:0]        col_r;
  logic [7:0]        char_r;
  logic [15:0]       num_r;
  logic [STEP_W-1:0] step;
  logic [2:0]        place;
  logic [3:0]        digit;
  logic              started;

  logic        in_take;
  logic        emit_go;
  logic        em_rs;
  logic [7:0]  em_byte;
  logic        em_extra;
  logic        em_bare;
  logic [3:0]  em_bare_nib;
  logic        em_last;
  logic [3:0]  em_nib;
  logic [12:0] em_after;
  logic [13:0] em_before;
  logic [7:0]  row_base;
  logic [15:0] pow;
  logic        num_ge;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign emit_go  = (state == S_EMIT) && (!out_valid || !out_stall);
  assign row_base = row_r ? CMD_ROW1 : CMD_ROW0;
  assign pow      = pow10(place);
  assign num_ge   = (num_r >= pow);

  always_comb begin
    em_rs       = 1'b0;
    em_byte     = CMD_CLEAR;
    em_extra    = 1'b0;
    em_bare     = 1'b0;
    em_bare_nib = NIB_WAKE;
    em_last     = 1'b0;
    unique case (func_r)
      FN_INIT: begin
        if (step < STEP_W'(4)) begin
          em_bare     = 1'b1;
          em_bare_nib = (step == STEP_W'(3)) ? NIB_4BIT : NIB_WAKE;
        end else begin
          unique case (step[3:1])
            3'd2:    em_byte = CMD_FUNC_SET;
            3'd3:    em_byte = CMD_DISP_ON;
            3'd4:    em_byte = CMD_ENTRY;
            default: begin
              em_byte  = CMD_CLEAR;
              em_extra = 1'b1;
            end
          endcase
        end
        em_last = (step == STEP_W'(11));
      end
      FN_CLEAR: begin
        em_byte  = CMD_CLEAR;
        em_extra = 1'b1;
        em_last  = (step == STEP_W'(1));
      end
      FN_CURSOR: begin
        em_byte = row_base + {2'b00, col_r};
        em_last = (step == STEP_W'(1));
      end
      FN_LINE: begin
        if (step < STEP_W'(2) || step >= STEP_W'(2 * LINE_CHARS + 2)) begin
          em_byte = row_base;
        end else begin
          em_rs   = 1'b1;
          em_byte = CHAR_SPACE;
        end
        em_last = (step == STEP_W'(2 * LINE_CHARS + 3));
      end
      FN_CHAR: begin
        em_rs   = 1'b1;
        em_byte = char_r;
        em_last = (step == STEP_W'(1));
      end
      FN_NUMBER: begin
        em_rs   = 1'b1;
        em_byte = CHAR_ZERO + {4'b0000, digit};
        em_last = step[0] && (place == PLACE_LAST);
      end
      default: begin
        em_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    em_nib = em_bare ? em_bare_nib : (step[0] ? em_byte[3:0] : em_byte[7:4]);
    if (em_bare) begin
      em_after = (step == '0) ? WAIT_POWER : WAIT_LOW;
    end else if (step[0]) begin
      em_after = em_extra ? WAIT_CLEAR : WAIT_LOW;
    end else begin
      em_after = WAIT_HIGH;
    end
    em_before = (func_r == FN_INIT && step == '0) ? WAIT_BOOT : 14'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (func == FN_NUMBER) begin
              state <= S_DIGIT;
            end else if (func <= FN_NUMBER) begin
              state <= S_EMIT;
            end
          end
        end
        S_DIGIT: begin
          if (!num_ge && (digit != 4'd0 || started || place == PLACE_LAST)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            if (em_last) begin
              state <= S_IDLE;
            end else if (func_r == FN_NUMBER && step[0]) begin
              state <= S_DIGIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r  <= func_t'(func);
      row_r   <= row;
      col_r   <= col;
      char_r  <= char_code;
      num_r   <= number;
      step    <= '0;
      place   <= 3'd0;
      digit   <= 4'd0;
      started <= 1'b0;
    end
    if (state == S_DIGIT) begin
      if (num_ge) begin
        num_r <= num_r - pow;
        digit <= digit + 4'd1;
      end else if (digit != 4'd0 || started || place == PLACE_LAST) begin
        started <= 1'b1;
        step    <= '0;
      end else begin
        place <= place + 3'd1;
      end
    end
    if (emit_go) begin
      reg_select     <= em_rs;
      nibble         <= em_nib;
      wait_before_us <= em_before;
      wait_after_us  <= em_after;
      last           <= em_last;
      step           <= step + STEP_W'(1);
      if (func_r == FN_NUMBER && step[0] && !em_last) begin
        place <= place + 3'd1;
        digit <= 4'd0;
      end
    end
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> out_valid)
    else $error("transfer loaded without valid");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_go && em_last) |=> (state == S_IDLE))
    else $error("sequencer busy after final transfer");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT) |-> (digit <= 4'd9 && place <= PLACE_LAST))
    else $error("decimal digit out of range");

  a_boot_wait: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wait_before_us != 14'd0) |-> (nibble == NIB_WAKE && !reg_select))
    else $error("power-up wait on wrong transfer");

endmodule
